FILE: rtl/ctri_pkg.sv
// shared constants, types and command struct for the cubic trajectory interpolator
`default_nettype none

package ctri_pkg;

    // default fractional bits of the position format
    localparam int POS_FRAC_BITS_DEF = 20;

    // speed factor after reset, unsigned Q8.8 (0.25)
    localparam logic [15:0] SPEED_RESET = 16'd64;

    // item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // shift-subtract unit: source word, partial remainder, step counter
    localparam int SRC_W  = 68;
    localparam int REM_W  = 38;
    localparam int STEP_W = 7;

    // iteration counts of the fixed-length runs
    localparam logic [STEP_W-1:0] SQRT_STEPS  = 7'd34;
    localparam logic [STEP_W-1:0] PHASE_STEPS = 7'd30;

    // duration constants: 1.5/vmax in us, 6/amax split in two factors
    localparam logic [MUL_W-1:0] TV_K  = 34'd750000;
    localparam logic [MUL_W-1:0] TA_K1 = 34'd2400000;
    localparam logic [MUL_W-1:0] TA_K2 = 34'd1000000;

    // unity in Q1.30 phase format
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // command to the shift-subtract unit
    typedef struct packed {
        logic                go;
        logic                is_sqrt;
        logic [STEP_W-1:0]   steps;
    } sd_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ctri_mul.sv
// shared registered unsigned multiplier
`default_nettype none

module ctri_mul
    import ctri_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    // product registered every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: rtl/ctri_sqdiv.sv
// shared shift-subtract unit: integer square root and restoring division
`default_nettype none

module ctri_sqdiv
    import ctri_pkg::*;
#(
    parameter int RES_W = 42
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sd_cmd_t          cmd,
    input  logic [SRC_W-1:0] src,
    input  logic [31:0]      rem_init,
    input  logic [31:0]      divisor,
    output logic             busy,
    output logic [RES_W-1:0] res
);

    logic                busy_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                sqrt_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [RES_W-1:0]    res_reg;
    logic [SRC_W-1:0]    src_reg;
    logic [31:0]         div_reg;

    logic [REM_W-1:0]    cand;
    logic [REM_W-1:0]    sub;
    logic [REM_W:0]      diff;
    logic                ge;

    // one root bit or one quotient bit per step
    always_comb
    begin
        if (sqrt_reg)
        begin
            cand = {rem_reg[REM_W-3:0], src_reg[SRC_W-1 -: 2]};
            sub  = {res_reg[REM_W-3:0], 2'b01};
        end
        else
        begin
            cand = {rem_reg[REM_W-2:0], src_reg[SRC_W-1]};
            sub  = {{(REM_W-32){1'b0}}, div_reg};
        end
        diff = {1'b0, cand} - {1'b0, sub};
        ge   = ~diff[REM_W];
    end

    // run control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            sqrt_reg <= 1'b0;
        end
        else if (cmd.go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cmd.steps;
            sqrt_reg <= cmd.is_sqrt;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            rem_reg <= {{(REM_W-32){1'b0}}, rem_init};
            res_reg <= '0;
            src_reg <= src;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : cand;
            res_reg <= {res_reg[RES_W-2:0], ge};
            src_reg <= sqrt_reg ? {src_reg[SRC_W-3:0], 2'b00} : {src_reg[SRC_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

FILE: rtl/cubic_trajectory_interpolator.sv
// top level: sequencer and state of the cubic point-to-point interpolator
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    mode, start_x/y/z, goal_x/y/z, step_us
//  out      output     out_valid/out_ready  pos_x/y/z, finished
//  cfg      input      cfg_valid/cfg_ready  speed_scale
//
// a start item runs two 34-step square roots and a division of TB_W + 8 steps (42
// at the default format) in the shift-subtract unit, plus seven passes through the multiplier
// a tick item runs a 30-step division and five multiplies; only the three position
// multiplies when it ends the move or arrives while idle
// in_ready is high only while the sequencer is idle; one item at a time
// the result sits in an output register, so a stalled out channel holds only the next tick
// reset is asynchronous and leaves the block idle with speed 0.25 and no move
`default_nettype none

module cubic_trajectory_interpolator
    import ctri_pkg::*;
#(
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    input  logic signed [31:0] goal_z,
    input  logic [15:0]        step_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               finished,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        speed_scale
);

    localparam int TV_W = 54 - POS_FRAC_BITS;
    localparam int TB_W = (TV_W > 34) ? TV_W : 34;
    localparam int QS_W = TB_W + 8;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SQ_MUL    = 5'd1;
    localparam logic [4:0] S_SQ_ACC    = 5'd2;
    localparam logic [4:0] S_DIST_GO   = 5'd3;
    localparam logic [4:0] S_DIST_WAIT = 5'd4;
    localparam logic [4:0] S_TV_MUL    = 5'd5;
    localparam logic [4:0] S_TV_ACC    = 5'd6;
    localparam logic [4:0] S_A_MUL     = 5'd7;
    localparam logic [4:0] S_A_ACC     = 5'd8;
    localparam logic [4:0] S_AL_MUL    = 5'd9;
    localparam logic [4:0] S_AL_ACC    = 5'd10;
    localparam logic [4:0] S_AH_MUL    = 5'd11;
    localparam logic [4:0] S_AH_ACC    = 5'd12;
    localparam logic [4:0] S_TA_GO     = 5'd13;
    localparam logic [4:0] S_TA_WAIT   = 5'd14;
    localparam logic [4:0] S_DUR_GO    = 5'd15;
    localparam logic [4:0] S_DUR_WAIT  = 5'd16;
    localparam logic [4:0] S_TK_CHK    = 5'd17;
    localparam logic [4:0] S_U_GO      = 5'd18;
    localparam logic [4:0] S_U_WAIT    = 5'd19;
    localparam logic [4:0] S_U2_MUL    = 5'd20;
    localparam logic [4:0] S_U2_ACC    = 5'd21;
    localparam logic [4:0] S_U3_MUL    = 5'd22;
    localparam logic [4:0] S_U3_ACC    = 5'd23;
    localparam logic [4:0] S_P_MUL     = 5'd24;
    localparam logic [4:0] S_P_ACC     = 5'd25;
    localparam logic [4:0] S_OUT       = 5'd26;

    localparam int ACC_W = 76;

    // control state
    logic [4:0]          state_reg;
    logic [1:0]          idx_reg;
    logic                active_reg;
    logic                out_valid_reg;
    logic [15:0]         speed_reg;

    // move state and working registers
    logic signed [31:0]  origin_reg [3];
    logic signed [32:0]  delta_reg  [3];
    logic [31:0]         elapsed_reg;
    logic [31:0]         dur_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [33:0]         dist_reg;
    logic [TV_W-1:0]     tv_reg;
    logic [33:0]         ta_reg;
    logic [55:0]         a_reg;
    logic [29:0]         u_reg;
    logic [29:0]         u2_reg;
    logic [30:0]         s_reg;
    logic                done_reg;
    logic signed [31:0]  pos_reg [3];
    logic signed [31:0]  pos_x_reg;
    logic signed [31:0]  pos_y_reg;
    logic signed [31:0]  pos_z_reg;
    logic                finished_reg;

    // shared units
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod;
    sd_cmd_t             sd_cmd;
    logic [SRC_W-1:0]    sd_src;
    logic [31:0]         sd_rem;
    logic [31:0]         sd_div;
    logic                sd_busy;
    logic [QS_W-1:0]     sd_res;

    logic                in_acc;
    logic signed [32:0]  delta_sel;
    logic                delta_neg;
    logic [31:0]         mag;
    logic [32:0]         elapsed_sum;
    logic [TB_W-1:0]     tb;
    logic [QS_W-1:0]     dividend;
    logic [ACC_W-1:0]    ta_shift;
    logic [15:0]         spd;
    logic [31:0]         s_calc;
    logic signed [63:0]  p_mag;
    logic signed [63:0]  p_signed;
    logic signed [63:0]  p_shift;
    logic signed [31:0]  pos_calc;

    ctri_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    ctri_sqdiv #(
        .RES_W (QS_W)
    ) u_sqdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (sd_cmd),
        .src      (sd_src),
        .rem_init (sd_rem),
        .divisor  (sd_div),
        .busy     (sd_busy),
        .res      (sd_res)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // magnitude of the selected axis delta
    always_comb
    begin
        delta_sel = delta_reg[idx_reg];
        delta_neg = delta_sel[32];
        mag       = delta_neg ? 32'(-delta_sel) : delta_sel[31:0];
    end

    // derived values for the sequencer
    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_reg} + {17'd0, step_us};
        tb          = (TB_W'(tv_reg) > TB_W'(ta_reg)) ? TB_W'(tv_reg) : TB_W'(ta_reg);
        dividend    = {tb, 8'd0};
        ta_shift    = acc_reg >> POS_FRAC_BITS;
        spd         = (speed_reg == 16'd0) ? 16'd1 : speed_reg;
        s_calc      = ({2'b00, u2_reg} << 1) + {2'b00, u2_reg} - ({2'b00, prod[59:30]} << 1);
        p_mag       = $signed({2'b00, prod[61:0]});
        p_signed    = delta_neg ? -p_mag : p_mag;
        p_shift     = p_signed >>> 30;
        pos_calc    = origin_reg[idx_reg] + p_shift[31:0];
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = MUL_W'(mag);
                mul_b = MUL_W'(mag);
            end
            S_TV_MUL:
            begin
                mul_a = dist_reg;
                mul_b = TV_K;
            end
            S_A_MUL:
            begin
                mul_a = dist_reg;
                mul_b = TA_K1;
            end
            S_AL_MUL:
            begin
                mul_a = MUL_W'(a_reg[31:0]);
                mul_b = TA_K2;
            end
            S_AH_MUL:
            begin
                mul_a = MUL_W'(a_reg[55:32]);
                mul_b = TA_K2;
            end
            S_U2_MUL:
            begin
                mul_a = MUL_W'(u_reg);
                mul_b = MUL_W'(u_reg);
            end
            S_U3_MUL:
            begin
                mul_a = MUL_W'(u2_reg);
                mul_b = MUL_W'(u_reg);
            end
            S_P_MUL:
            begin
                mul_a = MUL_W'(mag);
                mul_b = MUL_W'(s_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shift-subtract unit commands
    always_comb
    begin
        sd_cmd  = '0;
        sd_src  = '0;
        sd_rem  = '0;
        sd_div  = '0;
        unique case (state_reg)
            S_DIST_GO:
            begin
                sd_cmd.go      = 1'b1;
                sd_cmd.is_sqrt = 1'b1;
                sd_cmd.steps   = SQRT_STEPS;
                sd_src         = acc_reg[SRC_W-1:0];
            end
            S_TA_GO:
            begin
                sd_cmd.go      = 1'b1;
                sd_cmd.is_sqrt = 1'b1;
                sd_cmd.steps   = SQRT_STEPS;
                sd_src         = ta_shift[SRC_W-1:0];
            end
            S_DUR_GO:
            begin
                sd_cmd.go      = 1'b1;
                sd_cmd.steps   = STEP_W'(QS_W);
                sd_src         = {dividend, {(SRC_W-QS_W){1'b0}}};
                sd_div         = {16'd0, spd};
            end
            S_U_GO:
            begin
                sd_cmd.go      = 1'b1;
                sd_cmd.steps   = PHASE_STEPS;
                sd_rem         = elapsed_reg;
                sd_div         = dur_reg;
            end
            default:
            begin
                sd_cmd = '0;
            end
        endcase
    end

    // sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            speed_reg     <= SPEED_RESET;
            elapsed_reg   <= '0;
            dur_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                delta_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                speed_reg <= speed_scale;
            end
            // taken result leaves unless a new one replaces it below
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        idx_reg <= 2'd0;
                        if (mode == MODE_START)
                        begin
                            origin_reg[0] <= start_x;
                            origin_reg[1] <= start_y;
                            origin_reg[2] <= start_z;
                            delta_reg[0]  <= 33'(goal_x) - 33'(start_x);
                            delta_reg[1]  <= 33'(goal_y) - 33'(start_y);
                            delta_reg[2]  <= 33'(goal_z) - 33'(start_z);
                            state_reg     <= S_SQ_MUL;
                        end
                        else
                        begin
                            if (active_reg)
                            begin
                                elapsed_reg <= elapsed_sum[32] ? 32'hFFFF_FFFF
                                                               : elapsed_sum[31:0];
                            end
                            state_reg <= S_TK_CHK;
                        end
                    end
                end
                S_SQ_MUL:    state_reg <= S_SQ_ACC;
                S_SQ_ACC:
                begin
                    idx_reg   <= idx_reg + 2'd1;
                    state_reg <= (idx_reg == 2'd2) ? S_DIST_GO : S_SQ_MUL;
                end
                S_DIST_GO:   state_reg <= S_DIST_WAIT;
                S_DIST_WAIT:
                begin
                    if (!sd_busy)
                    begin
                        state_reg <= S_TV_MUL;
                    end
                end
                S_TV_MUL:    state_reg <= S_TV_ACC;
                S_TV_ACC:    state_reg <= S_A_MUL;
                S_A_MUL:     state_reg <= S_A_ACC;
                S_A_ACC:     state_reg <= S_AL_MUL;
                S_AL_MUL:    state_reg <= S_AL_ACC;
                S_AL_ACC:    state_reg <= S_AH_MUL;
                S_AH_MUL:    state_reg <= S_AH_ACC;
                S_AH_ACC:    state_reg <= S_TA_GO;
                S_TA_GO:     state_reg <= S_TA_WAIT;
                S_TA_WAIT:
                begin
                    if (!sd_busy)
                    begin
                        state_reg <= S_DUR_GO;
                    end
                end
                S_DUR_GO:    state_reg <= S_DUR_WAIT;
                S_DUR_WAIT:
                begin
                    if (!sd_busy)
                    begin
                        dur_reg     <= (|sd_res[QS_W-1:32]) ? 32'hFFFF_FFFF : sd_res[31:0];
                        elapsed_reg <= '0;
                        active_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_TK_CHK:
                begin
                    if (!active_reg || (elapsed_reg >= dur_reg))
                    begin
                        active_reg <= 1'b0;
                        state_reg  <= S_P_MUL;
                    end
                    else
                    begin
                        state_reg <= S_U_GO;
                    end
                end
                S_U_GO:      state_reg <= S_U_WAIT;
                S_U_WAIT:
                begin
                    if (!sd_busy)
                    begin
                        state_reg <= S_U2_MUL;
                    end
                end
                S_U2_MUL:    state_reg <= S_U2_ACC;
                S_U2_ACC:    state_reg <= S_U3_MUL;
                S_U3_MUL:    state_reg <= S_U3_ACC;
                S_U3_ACC:    state_reg <= S_P_MUL;
                S_P_MUL:     state_reg <= S_P_ACC;
                S_P_ACC:
                begin
                    idx_reg   <= idx_reg + 2'd1;
                    state_reg <= (idx_reg == 2'd2) ? S_OUT : S_P_MUL;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    // working datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                acc_reg <= '0;
            end
            S_SQ_ACC:
            begin
                acc_reg <= acc_reg + ACC_W'(prod);
            end
            S_DIST_WAIT:
            begin
                dist_reg <= sd_res[33:0];
            end
            S_TV_ACC:
            begin
                tv_reg <= prod[53:POS_FRAC_BITS];
            end
            S_A_ACC:
            begin
                a_reg <= prod[55:0];
            end
            S_AL_ACC:
            begin
                acc_reg <= ACC_W'(prod);
            end
            S_AH_ACC:
            begin
                acc_reg <= acc_reg + (ACC_W'(prod) << 32);
            end
            S_TA_WAIT:
            begin
                ta_reg <= sd_res[33:0];
            end
            S_TK_CHK:
            begin
                s_reg    <= Q30_ONE;
                done_reg <= 1'b1;
            end
            S_U_WAIT:
            begin
                u_reg    <= sd_res[29:0];
                done_reg <= 1'b0;
            end
            S_U2_ACC:
            begin
                u2_reg <= prod[59:30];
            end
            S_U3_ACC:
            begin
                s_reg <= s_calc[30:0];
            end
            S_P_ACC:
            begin
                pos_reg[idx_reg] <= pos_calc;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
        begin
            pos_x_reg    <= pos_reg[0];
            pos_y_reg    <= pos_reg[1];
            pos_z_reg    <= pos_reg[2];
            finished_reg <= done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign finished  = finished_reg;

endmodule

`default_nettype wire

FILE: rtl/ctri_checker.sv
// port-level assertions for the cubic trajectory interpolator, with bind
`default_nettype none

module ctri_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] pos_x,
    input  logic        finished
);

    // a held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pos_x) && $stable(finished))
        else $error("result changed while stalled");

    // the block goes busy after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken back to back");

    // no result can appear in the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared without work");

endmodule

bind cubic_trajectory_interpolator ctri_checker u_ctri_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .finished  (finished)
);

`default_nettype wire
